// File: hw/rtl/cfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, register indexes, status codes and the CRC-16 byte step
// for the start-of-frame / length / CRC-16 deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOF_FIRST     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOF_SECOND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_VALUE = 2'd2;

    // frame-end status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_VER = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

    // result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // crc-16 ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // header layout: version, type, flags, seq lo/hi, length lo/hi
    localparam logic [2:0] HDR_VERSION = 3'd0;
    localparam logic [2:0] HDR_TYPE    = 3'd1;
    localparam logic [2:0] HDR_FLAGS   = 3'd2;
    localparam logic [2:0] HDR_SEQ_LO  = 3'd3;
    localparam logic [2:0] HDR_SEQ_HI  = 3'd4;
    localparam logic [2:0] HDR_LEN_LO  = 3'd5;
    localparam logic [2:0] HDR_LEN_HI  = 3'd6;

    typedef struct packed {
        logic [7:0] sof_first;
        logic [7:0] sof_second;
        logic [7:0] version_value;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic [15:0] msg_seq;
        logic [15:0] payload_length;
        logic [1:0]  status;
    } t_result;

    // one byte through the crc, msb first, unrolled over eight bits
    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cfd_intf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfd interfaces
// Valid/ready channels of the deframer: received bytes, results and
// configuration writes.
// ----------------------------------------------------------------------------

// received byte channel
interface cfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface cfd_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_type;
    logic [7:0]  msg_flags;
    logic [15:0] msg_seq;
    logic [15:0] payload_length;
    logic [1:0]  status;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output msg_type, output msg_flags, output msg_seq,
                    output payload_length, output status, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input msg_type, input msg_flags, input msg_seq,
                    input payload_length, input status, output ready);
endinterface

// configuration write channel
interface cfd_cfg_if import cfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cfd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_cfg_regs
// Configuration register file: start bytes and expected version, written
// through the configuration channel, always ready.
// ----------------------------------------------------------------------------
module cfd_cfg_regs
    import cfd_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    cfd_cfg_if.sink i_cfg,
    output t_cfg o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // decode a write request; unused indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SOF_FIRST:     n_cfg.sof_first     = i_cfg.data;
                CFG_SOF_SECOND:    n_cfg.sof_second    = i_cfg.data;
                CFG_VERSION_VALUE: n_cfg.version_value = i_cfg.data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/cfd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_core
// Frame state machine with running CRC and header capture; one byte per
// cycle while the output register is free or drained, results go into an output register toward the result channel.
// ----------------------------------------------------------------------------
module cfd_core
    import cfd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cfg       i_cfg,
    input  wire        i_byte_valid,
    input  wire  [7:0] i_byte,
    output logic       o_byte_ready,
    cfd_res_if.source  o_res
);

    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_SOF2   = 6'b000010,
        PH_HEADER = 6'b000100,
        PH_BODY   = 6'b001000,
        PH_CRCLO  = 6'b010000,
        PH_CRCHI  = 6'b100000
    } t_phase;

    t_phase      r_phase,          n_phase;
    logic [2:0]  r_header_count,   n_header_count;
    logic [7:0]  r_held_type,      n_held_type;
    logic [7:0]  r_held_flags,     n_held_flags;
    logic [15:0] r_held_seq,       n_held_seq;
    logic [15:0] r_held_length,    n_held_length;
    logic [15:0] r_payload_count,  n_payload_count;
    logic [15:0] r_crc,            n_crc;
    logic [7:0]  r_crc_first_byte, n_crc_first_byte;
    logic        r_version_match,  n_version_match;

    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        n_emit;
    logic        take;
    logic [15:0] crc_next;
    logic [15:0] pc_inc;
    logic [15:0] crc_recv;

    // accept a byte whenever the output register is free or being drained
    assign o_byte_ready = !r_out_valid || o_res.ready;
    assign take         = i_byte_valid && o_byte_ready;

    assign crc_next = crc16_step(r_crc, i_byte);
    assign pc_inc   = r_payload_count + 16'd1;
    assign crc_recv = {i_byte, r_crc_first_byte};

    // next state and result for the byte at hand
    always_comb begin
        n_phase          = r_phase;
        n_header_count   = r_header_count;
        n_held_type      = r_held_type;
        n_held_flags     = r_held_flags;
        n_held_seq       = r_held_seq;
        n_held_length    = r_held_length;
        n_payload_count  = r_payload_count;
        n_crc            = r_crc;
        n_crc_first_byte = r_crc_first_byte;
        n_version_match  = r_version_match;
        n_out            = '0;
        n_emit           = 1'b0;

        unique case (r_phase)
            PH_SOF2: begin
                if (i_byte == i_cfg.sof_second) begin
                    n_phase        = PH_HEADER;
                    n_header_count = '0;
                    n_crc          = CRC_INIT;
                end else if (i_byte != i_cfg.sof_first) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_HEADER: begin
                n_crc = crc_next;
                unique case (r_header_count)
                    HDR_VERSION: n_version_match = (i_byte == i_cfg.version_value);
                    HDR_TYPE:    n_held_type     = i_byte;
                    HDR_FLAGS:   n_held_flags    = i_byte;
                    HDR_SEQ_LO:  n_held_seq      = {r_held_seq[15:8], i_byte};
                    HDR_SEQ_HI:  n_held_seq      = {i_byte, r_held_seq[7:0]};
                    HDR_LEN_LO:  n_held_length   = {r_held_length[15:8], i_byte};
                    default:     n_held_length   = {i_byte, r_held_length[7:0]};
                endcase
                if (r_header_count == HDR_LEN_HI) begin
                    n_header_count  = '0;
                    n_payload_count = '0;
                    n_phase = (n_held_length == 16'd0) ? PH_CRCLO : PH_BODY;
                end else begin
                    n_header_count = r_header_count + 3'd1;
                end
            end
            PH_BODY: begin
                n_crc            = crc_next;
                n_emit           = 1'b1;
                n_out.kind       = KIND_PAYLOAD;
                n_out.data_byte  = i_byte;
                n_out.byte_index = r_payload_count;
                n_payload_count  = pc_inc;
                if (pc_inc == r_held_length) begin
                    n_phase = PH_CRCLO;
                end
            end
            PH_CRCLO: begin
                n_crc_first_byte = i_byte;
                n_phase          = PH_CRCHI;
            end
            PH_CRCHI: begin
                n_emit               = 1'b1;
                n_out.kind           = KIND_FRAME_END;
                n_out.msg_type       = r_held_type;
                n_out.msg_flags      = r_held_flags;
                n_out.msg_seq        = r_held_seq;
                n_out.payload_length = r_held_length;
                if (!r_version_match) begin
                    n_out.status = STATUS_BAD_VER;
                end else if (crc_recv != r_crc) begin
                    n_out.status = STATUS_BAD_CRC;
                end else begin
                    n_out.status = STATUS_OK;
                end
                n_phase = PH_HUNT;
            end
            // hunting, and any code with no meaning
            default: begin
                n_phase = (i_byte == i_cfg.sof_first) ? PH_SOF2 : PH_HUNT;
            end
        endcase
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HUNT;
            r_header_count   <= '0;
            r_held_type      <= '0;
            r_held_flags     <= '0;
            r_held_seq       <= '0;
            r_held_length    <= '0;
            r_payload_count  <= '0;
            r_crc            <= CRC_INIT;
            r_crc_first_byte <= '0;
            r_version_match  <= 1'b0;
        end else if (take) begin
            r_phase          <= n_phase;
            r_header_count   <= n_header_count;
            r_held_type      <= n_held_type;
            r_held_flags     <= n_held_flags;
            r_held_seq       <= n_held_seq;
            r_held_length    <= n_held_length;
            r_payload_count  <= n_payload_count;
            r_crc            <= n_crc;
            r_crc_first_byte <= n_crc_first_byte;
            r_version_match  <= n_version_match;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= n_emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out.kind;
    assign o_res.data_byte      = r_out.data_byte;
    assign o_res.byte_index     = r_out.byte_index;
    assign o_res.msg_type       = r_out.msg_type;
    assign o_res.msg_flags      = r_out.msg_flags;
    assign o_res.msg_seq        = r_out.msg_seq;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.status         = r_out.status;

    // a frame end always returns to hunting
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == PH_CRCHI) |=> (r_phase == PH_HUNT))
        else $error("frame end did not return to hunting");

    // payload offset stays below the declared length
    a_body_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_payload_count < r_held_length))
        else $error("payload count beyond declared length");

    // header counter stays within the seven header bytes
    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_header_count <= HDR_LEN_HI))
        else $error("header count out of range");

    // a version mismatch wins over any crc verdict
    a_ver_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == PH_CRCHI && !r_version_match)
        |=> (o_res.valid && o_res.status == STATUS_BAD_VER))
        else $error("version mismatch not reported");

endmodule
`default_nettype wire

// File: hw/rtl/crc16_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_deframer
// Start-of-frame / length / CRC-16 deframer: passes payload bytes out as
// they arrive and reports header and verdict at the end of each frame.
// ----------------------------------------------------------------------------
// Path: an accepted request lands in the input register, and the frame
//   logic loads the result register when it takes that byte from there, so a
//   result is offered only after it has passed both register stages.
// Throughput: one byte per cycle while results are taken; a waiting result
//   stalls the input once both register stages are full.
// Reset (synchronous, active low): hunting, crc 0xFFFF, frame and config registers zero, stages empty.
module crc16_frame_deframer
    import cfd_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    cfd_cfg_if.sink  i_cfg,
    cfd_byte_if.sink i_rx,
    cfd_res_if.source o_res
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       core_ready;

    // configuration registers
    cfd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // input register: refills in the cycle its byte moves on
    assign i_rx.ready = !r_in_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // frame logic and result register
    cfd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_byte_valid (r_in_valid),
        .i_byte       (r_in_byte),
        .o_byte_ready (core_ready),
        .o_res        (o_res)
    );

endmodule
`default_nettype wire
